// ----- rtl/core/hddc_pkg.sv -----
// ----------------------------------------------------------------------------
// hddc_pkg
// Shared types, codes and helpers of the heading and distance drive controller.
// ----------------------------------------------------------------------------
package hddc_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEADING_GAIN = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_GAIN    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAR_WINDOW   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEAR_WINDOW  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CREEP_SPEED  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_TICKS = 3'd6;

   typedef enum logic [1:0] {
      KIND_TICK     = 2'd0,
      KIND_SPEED    = 2'd1,
      KIND_DISTANCE = 2'd2,
      KIND_ENCODER  = 2'd3
   } kind_type;

   // One registered input item; heading and rate are already scaled.
   typedef struct packed {
      kind_type           kind;
      logic [8:0]         heading;    // wrapped to 0..359
      logic signed [11:0] rate_dps;   // yaw rate in deg/s
      logic signed [9:0]  angle;
      logic               relative;
      logic signed [15:0] speed;
      logic signed [23:0] distance;
      logic               wheel;
      logic               phase_a;
      logic               phase_b;
   } item_type;

   typedef struct packed {
      logic [8:0] err;        // target minus heading, 0..359
      logic       in_band;    // inside the deadband
      logic       left_leads; // left wheel gets the positive turn drive
      logic [7:0] turn;       // turn drive magnitude, clamped to 0..255
   } turn_type;

   typedef struct packed {
      logic step;
      logic wheel;
      logic phase_a;
      logic phase_b;
      logic clear;
   } odom_cmd_type;

   function automatic logic signed [7:0] sat_drive(input logic signed [9:0] v);
      logic signed [7:0] r;
      if (v > 10'sd100) begin
         r = 8'sd100;
      end else if (v < -10'sd100) begin
         r = -8'sd100;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/hddc_front.sv -----
// ----------------------------------------------------------------------------
// hddc_front
// Input register: captures one transfer, wraps heading and scales yaw rate.
// ----------------------------------------------------------------------------
module hddc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic signed [8:0]   req_heading_deg,
   input  logic signed [15:0]  req_gyro_rate_raw,
   input  logic signed [9:0]   req_angle_arg,
   input  logic                req_relative_flag,
   input  logic signed [15:0]  req_speed_arg,
   input  logic signed [23:0]  req_distance_arg,
   input  logic                req_wheel_select,
   input  logic                req_phase_a,
   input  logic                req_phase_b,
   input  logic                advance,
   output logic                item_valid,
   output hddc_pkg::item_type  item
);
   import hddc_pkg::*;

   logic               valid_ff;
   item_type           item_ff;
   item_type           item_in;
   logic [10:0]        head_sum;
   logic signed [26:0] rate_prod;
   logic signed [26:0] rate_adj;

   // deg/s = raw * 2000 / 32768, truncated toward zero
   always_comb begin
      head_sum  = 11'd360 + 11'(req_heading_deg);
      rate_prod = 27'(req_gyro_rate_raw) * 27'sd2000;
      rate_adj  = rate_prod + (rate_prod[26] ? 27'sd32767 : 27'sd0);

      item_in.kind     = kind_type'(req_kind);
      item_in.heading  = (head_sum >= 11'd360) ? 9'(head_sum - 11'd360) : head_sum[8:0];
      item_in.rate_dps = rate_adj[26:15];
      item_in.angle    = req_angle_arg;
      item_in.relative = req_relative_flag;
      item_in.speed    = req_speed_arg;
      item_in.distance = req_distance_arg;
      item_in.wheel    = req_wheel_select;
      item_in.phase_a  = req_phase_a;
      item_in.phase_b  = req_phase_b;
   end

   assign req_ready  = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- rtl/core/hddc_turn.sv -----
// ----------------------------------------------------------------------------
// hddc_turn
// PD turn law: wrapped heading error, deadband test and turn drive magnitude.
// ----------------------------------------------------------------------------
module hddc_turn (
   input  logic [8:0]          target_heading,
   input  logic [8:0]          heading,
   input  logic signed [11:0]  rate_dps,
   input  logic [7:0]          heading_gain,
   input  logic [7:0]          rate_gain,
   input  logic [6:0]          deadband_deg,
   output hddc_pkg::turn_type  turn
);
   import hddc_pkg::*;

   logic [9:0]         diff;
   logic [8:0]         err;
   logic               right_side;
   logic [7:0]         mag;
   logic [15:0]        err_term;
   logic signed [19:0] rate_term;
   logic signed [21:0] drive;

   always_comb begin
      diff       = {1'b0, target_heading} - {1'b0, heading} + 10'd360;
      err        = (diff >= 10'd360) ? 9'(diff - 10'd360) : diff[8:0];
      right_side = err < 9'd180;
      mag        = right_side ? err[7:0] : 8'(9'd360 - err);
      err_term   = mag * heading_gain;
      rate_term  = $signed({1'b0, rate_gain}) * rate_dps;
      // damping opposes the turn direction
      drive      = $signed({6'b0, err_term})
                 + (right_side ? -22'(rate_term) : 22'(rate_term)) + 22'sd10;

      turn.err        = err;
      turn.in_band    = (err < {2'b0, deadband_deg}) ||
                        (err > (9'd360 - {2'b0, deadband_deg}));
      turn.left_leads = !right_side;
      if (turn.in_band || drive[21]) begin
         turn.turn = 8'd0;
      end else if (drive > 22'sd255) begin
         turn.turn = 8'd255;
      end else begin
         turn.turn = drive[7:0];
      end
   end

endmodule

// ----- rtl/core/hddc_odom.sv -----
// ----------------------------------------------------------------------------
// hddc_odom
// Quadrature odometry: per-wheel phase memory and wrapping up/down counts.
// ----------------------------------------------------------------------------
module hddc_odom #(
   parameter int COUNT_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hddc_pkg::odom_cmd_type     cmd,
   output logic signed [COUNT_BITS:0] count_sum
);
   import hddc_pkg::*;

   logic signed [COUNT_BITS-1:0] count_ff [2];
   logic [1:0]                   phase_ff;

   assign count_sum = (COUNT_BITS+1)'(count_ff[0]) + (COUNT_BITS+1)'(count_ff[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff[0] <= '0;
         count_ff[1] <= '0;
         phase_ff    <= '0;
      end else if (cmd.clear) begin
         count_ff[0] <= '0;
         count_ff[1] <= '0;
      end else if (cmd.step && (phase_ff[cmd.wheel] != cmd.phase_a)) begin
         // matching phases count up, differing phases count down
         count_ff[cmd.wheel] <= count_ff[cmd.wheel] +
            ((cmd.phase_a == cmd.phase_b) ? COUNT_BITS'(1) : {COUNT_BITS{1'b1}});
         phase_ff[cmd.wheel] <= cmd.phase_a;
      end
   end

endmodule

// ----- rtl/core/heading_distance_drive_controller.sv -----
// ----------------------------------------------------------------------------
// heading_distance_drive_controller
// Differential-drive heading (PD) and distance controller with odometry.
//
// Items arrive on the req_ channel (valid/ready); req_kind selects a control
// tick, a speed command, a distance command or an encoder edge. Only a tick
// produces a result on the rsp_ channel: both wheel drives, the busy flags
// and the wrapped heading error. The user must write registers on the csr_
// port only while the block is idle; the block itself does not enforce it.
// A tick's result passes the input register, then the result register, and
// is presented on rsp_; a stalled result register can hold it in between.
// Throughput: one item per cycle while no tick waits on a stalled result
// register, set by the single register-to-register pass of the turn law and
// distance logic. A new item is taken while a result still waits; only a tick
// that meets a full, stalled result register holds the input stage, and then
// req_ready drops until rsp_ready returns.
// Reset clears headings, speed, distance mode, wheel counts, hold counters
// and both channels, and loads the register reset values; no clearing
// pass follows.
// ----------------------------------------------------------------------------
module heading_distance_drive_controller #(
   parameter int COUNT_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_kind,
   input  logic signed [8:0]                     req_heading_deg,
   input  logic signed [15:0]                    req_gyro_rate_raw,
   input  logic signed [9:0]                     req_angle_arg,
   input  logic                                  req_relative_flag,
   input  logic signed [15:0]                    req_speed_arg,
   input  logic signed [23:0]                    req_distance_arg,
   input  logic                                  req_wheel_select,
   input  logic                                  req_phase_a,
   input  logic                                  req_phase_b,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [7:0]                     rsp_left_drive,
   output logic signed [7:0]                     rsp_right_drive,
   output logic                                  rsp_turning_busy,
   output logic                                  rsp_distance_busy,
   output logic [8:0]                            rsp_heading_error,
   // register writes
   input  logic                                  csr_we,
   input  logic [hddc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [hddc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import hddc_pkg::*;

   // remaining distance needs room for the target and the sum of two counts
   localparam int RemBits = ((COUNT_BITS > 24) ? COUNT_BITS : 24) + 2;

   // configuration registers
   logic [7:0]  heading_gain_ff, rate_gain_ff, settle_ticks_ff;
   logic [6:0]  deadband_ff, creep_speed_ff;
   logic [15:0] far_window_ff, near_window_ff;

   // controller state
   logic [8:0]         target_heading_ff, target_heading_in;
   logic [8:0]         last_heading_ff, last_heading_in;
   logic signed [7:0]  speed_ff, speed_in;
   logic signed [23:0] dist_target_ff, dist_target_in;
   logic [7:0]         turn_hold_ff, turn_hold_in;
   logic [7:0]         settle_hold_ff, settle_hold_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]  left_ff, left_in, right_ff, right_in;
   logic               turning_ff, turning_in, dist_busy_ff, dist_busy_in;
   logic [8:0]         err_ff;

   // datapath
   item_type                item;
   logic                    item_valid;
   logic                    advance;
   logic                    is_tick;
   turn_type                turn;
   odom_cmd_type            odom_cmd;
   logic signed [COUNT_BITS:0] count_sum;
   logic signed [11:0]      tgt_sum;
   logic [11:0]             tgt_a, tgt_b, tgt_c;
   logic [24:0]             dist_abs;
   logic signed [RemBits-1:0] rem, far_s, near_s;
   logic                    rem_pos, beyond_far, beyond_near;
   logic signed [7:0]       fwd;
   logic signed [9:0]       turn_s;

   hddc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_heading_deg   (req_heading_deg),
      .req_gyro_rate_raw (req_gyro_rate_raw),
      .req_angle_arg     (req_angle_arg),
      .req_relative_flag (req_relative_flag),
      .req_speed_arg     (req_speed_arg),
      .req_distance_arg  (req_distance_arg),
      .req_wheel_select  (req_wheel_select),
      .req_phase_a       (req_phase_a),
      .req_phase_b       (req_phase_b),
      .advance           (advance),
      .item_valid        (item_valid),
      .item              (item)
   );

   hddc_turn u_turn (
      .target_heading (target_heading_ff),
      .heading        (item.heading),
      .rate_dps       (item.rate_dps),
      .heading_gain   (heading_gain_ff),
      .rate_gain      (rate_gain_ff),
      .deadband_deg   (deadband_ff),
      .turn           (turn)
   );

   hddc_odom #(
      .COUNT_BITS (COUNT_BITS)
   ) u_odom (
      .clock     (clock),
      .reset     (reset),
      .cmd       (odom_cmd),
      .count_sum (count_sum)
   );

   // A tick needs a free result slot; other kinds pass straight through.
   assign is_tick = item.kind == KIND_TICK;
   assign advance = item_valid && (!is_tick || !rsp_valid_ff || rsp_ready);

   // Target heading: sum lies in 208..1590, fold it into 0..359.
   always_comb begin
      tgt_sum = 12'(item.angle) + 12'sd720 +
                (item.relative ? $signed({3'b0, last_heading_ff}) : 12'sd0);
      tgt_a   = tgt_sum;
      tgt_b   = (tgt_a >= 12'd1440) ? tgt_a - 12'd1440 : tgt_a;
      tgt_c   = (tgt_b >= 12'd720)  ? tgt_b - 12'd720  : tgt_b;
      tgt_c   = (tgt_c >= 12'd360)  ? tgt_c - 12'd360  : tgt_c;
   end

   // Remaining distance and window tests; the far window wins.
   always_comb begin
      dist_abs    = item.distance[23] ? -25'(item.distance) : 25'(item.distance);
      rem         = RemBits'(dist_target_ff) - RemBits'(count_sum);
      far_s       = $signed({{(RemBits-16){1'b0}}, far_window_ff});
      near_s      = $signed({{(RemBits-16){1'b0}}, near_window_ff});
      rem_pos     = !rem[RemBits-1] && (rem != '0);
      beyond_far  = (rem > far_s) || (rem < -far_s);
      beyond_near = (rem > near_s) || (rem < -near_s);
   end

   always_comb begin
      target_heading_in = target_heading_ff;
      last_heading_in   = last_heading_ff;
      speed_in          = speed_ff;
      dist_target_in    = dist_target_ff;
      turn_hold_in      = turn_hold_ff;
      settle_hold_in    = settle_hold_ff;
      odom_cmd          = '0;
      odom_cmd.wheel    = item.wheel;
      odom_cmd.phase_a  = item.phase_a;
      odom_cmd.phase_b  = item.phase_b;
      fwd               = speed_ff;
      turn_s            = $signed({2'b0, turn.turn});
      left_in           = 8'sd0;
      right_in          = 8'sd0;
      turning_in        = 1'b0;
      dist_busy_in      = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;

      if (advance) begin
         case (item.kind)
            KIND_SPEED: begin
               target_heading_in = tgt_c[8:0];
               if (item.speed > 16'sd100) begin
                  speed_in = 8'sd100;
               end else if (item.speed < -16'sd100) begin
                  speed_in = -8'sd100;
               end else begin
                  speed_in = item.speed[7:0];
               end
            end
            KIND_DISTANCE: begin
               target_heading_in = tgt_c[8:0];
               speed_in          = (dist_abs > 25'd40) ? 8'sd40 : $signed(dist_abs[7:0]);
               dist_target_in    = item.distance;
               settle_hold_in    = settle_ticks_ff;
               odom_cmd.clear    = 1'b1;
            end
            KIND_ENCODER: begin
               odom_cmd.step = 1'b1;
            end
            KIND_TICK: begin
               last_heading_in = item.heading;
               if (turn.in_band) begin
                  if (turn_hold_ff != 8'd0) begin
                     turn_hold_in = turn_hold_ff - 8'd1;
                  end
               end else begin
                  turn_hold_in = settle_ticks_ff;
               end

               if (dist_target_ff != 24'sd0) begin
                  if (beyond_far) begin
                     fwd            = rem_pos ? speed_ff : -speed_ff;
                     settle_hold_in = settle_ticks_ff;
                  end else if (beyond_near) begin
                     fwd            = rem_pos ? $signed({1'b0, creep_speed_ff})
                                              : -$signed({1'b0, creep_speed_ff});
                     settle_hold_in = settle_ticks_ff;
                  end else begin
                     fwd = 8'sd0;
                     if (settle_hold_ff != 8'd0) begin
                        settle_hold_in = settle_hold_ff - 8'd1;
                     end else begin
                        // settled: drop distance mode
                        dist_target_in = 24'sd0;
                        speed_in       = 8'sd0;
                        odom_cmd.clear = 1'b1;
                     end
                  end
               end

               // apply the turn drive opposite on the two wheels
               if (turn.left_leads) begin
                  left_in  = sat_drive(10'(fwd) + turn_s);
                  right_in = sat_drive(10'(fwd) - turn_s);
               end else begin
                  left_in  = sat_drive(10'(fwd) - turn_s);
                  right_in = sat_drive(10'(fwd) + turn_s);
               end
               turning_in   = turn_hold_in != 8'd0;
               dist_busy_in = dist_target_in != 24'sd0;
               rsp_valid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_gain_ff   <= 8'd2;
         rate_gain_ff      <= 8'd1;
         deadband_ff       <= 7'd5;
         far_window_ff     <= 16'd160;
         near_window_ff    <= 16'd16;
         creep_speed_ff    <= 7'd15;
         settle_ticks_ff   <= 8'd100;
         target_heading_ff <= '0;
         last_heading_ff   <= '0;
         speed_ff          <= '0;
         dist_target_ff    <= '0;
         turn_hold_ff      <= '0;
         settle_hold_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HEADING_GAIN: heading_gain_ff <= csr_wdata[7:0];
               CSR_RATE_GAIN:    rate_gain_ff    <= csr_wdata[7:0];
               CSR_DEADBAND:     deadband_ff     <= csr_wdata[6:0];
               CSR_FAR_WINDOW:   far_window_ff   <= csr_wdata;
               CSR_NEAR_WINDOW:  near_window_ff  <= csr_wdata;
               CSR_CREEP_SPEED:  creep_speed_ff  <= csr_wdata[6:0];
               CSR_SETTLE_TICKS: settle_ticks_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
         target_heading_ff <= target_heading_in;
         last_heading_ff   <= last_heading_in;
         speed_ff          <= speed_in;
         dist_target_ff    <= dist_target_in;
         turn_hold_ff      <= turn_hold_in;
         settle_hold_ff    <= settle_hold_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      // load the result payload only on a tick that advances
      if (advance && is_tick) begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         turning_ff   <= turning_in;
         dist_busy_ff <= dist_busy_in;
         err_ff       <= turn.err;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_drive    = left_ff;
   assign rsp_right_drive   = right_ff;
   assign rsp_turning_busy  = turning_ff;
   assign rsp_distance_busy = dist_busy_ff;
   assign rsp_heading_error = err_ff;

`ifndef SYNTH
   // a waiting result is never overwritten by the next tick
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(advance && is_tick))
      else $error("tick advanced into a stalled result register");

   // wrapped error stays below a full turn
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_heading_error < 9'd360))
      else $error("heading error out of range");

   // both wheel drives are saturated
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_left_drive >= -8'sd100 && rsp_left_drive <= 8'sd100 &&
                        rsp_right_drive >= -8'sd100 && rsp_right_drive <= 8'sd100))
      else $error("wheel drive out of range");

   // speed setpoint stays clamped
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      (speed_ff >= -8'sd100) && (speed_ff <= 8'sd100))
      else $error("speed setpoint out of range");
`endif

endmodule

// ----- bench/hddc_drive_checker.sv -----
// ----------------------------------------------------------------------------
// hddc_drive_checker
// Watches the item, result and register ports of the drive controller, keeps
// its own copy of the controller state, predicts the result of every control
// tick and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module hddc_drive_checker #(
   parameter int COUNT_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic signed [8:0]                    req_heading_deg,
   input  logic signed [15:0]                   req_gyro_rate_raw,
   input  logic signed [9:0]                    req_angle_arg,
   input  logic                                 req_relative_flag,
   input  logic signed [15:0]                   req_speed_arg,
   input  logic signed [23:0]                   req_distance_arg,
   input  logic                                 req_wheel_select,
   input  logic                                 req_phase_a,
   input  logic                                 req_phase_b,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [7:0]                    rsp_left_drive,
   input  logic signed [7:0]                    rsp_right_drive,
   input  logic                                 rsp_turning_busy,
   input  logic                                 rsp_distance_busy,
   input  logic [8:0]                           rsp_heading_error,
   input  logic                                 csr_we,
   input  logic [hddc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hddc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output int                                   fail_count,
   output int                                   pending_results
);

   timeunit 1ns;
   timeprecision 1ps;

   import hddc_pkg::*;

   typedef struct packed {
      logic signed [7:0] left;
      logic signed [7:0] right;
      logic              turning;
      logic              traveling;
      logic [8:0]        err;
   } drive_result_type;

   drive_result_type expected_drives[$];

   int heading_gain, rate_gain, deadband, far_window, near_window;
   int creep_speed, settle_ticks;

   int     target_hdg, last_hdg, speed_cmd, turn_hold, settle_hold;
   longint dist_target;
   logic signed [COUNT_BITS-1:0] wheel_cnt [2];
   logic                         phase_mem [2];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic signed [7:0] clamp_drive(input longint v);
      if (v > 100) return 8'sd100;
      if (v < -100) return -8'sd100;
      return v[7:0];
   endfunction

   // Absolute or relative target heading, folded into 0..359.
   function automatic int wrap_target(input int ang, input logic rel);
      int sum;
      sum = rel ? last_hdg + ang : ang;
      return (sum + 720) % 360;
   endfunction

   // Runs only while reset is held, which happens once at the start.
   task automatic restore_defaults();
      fail_count   = 0;
      heading_gain = 2;
      rate_gain    = 1;
      deadband     = 5;
      far_window   = 160;
      near_window  = 16;
      creep_speed  = 15;
      settle_ticks = 100;
      target_hdg   = 0;
      last_hdg     = 0;
      speed_cmd    = 0;
      turn_hold    = 0;
      settle_hold  = 0;
      dist_target  = 0;
      wheel_cnt[0] = '0;
      wheel_cnt[1] = '0;
      phase_mem[0] = 1'b0;
      phase_mem[1] = 1'b0;
      expected_drives.delete();
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_HEADING_GAIN: heading_gain = int'(data[7:0]);
         CSR_RATE_GAIN:    rate_gain    = int'(data[7:0]);
         CSR_DEADBAND:     deadband     = int'(data[6:0]);
         CSR_FAR_WINDOW:   far_window   = int'(data[15:0]);
         CSR_NEAR_WINDOW:  near_window  = int'(data[15:0]);
         CSR_CREEP_SPEED:  creep_speed  = int'(data[6:0]);
         CSR_SETTLE_TICKS: settle_ticks = int'(data[7:0]);
         default: ;
      endcase
   endtask

   // Apply one accepted item to the state; a tick queues its drive result.
   task automatic advance_controller();
      int               spd, hdg, err;
      longint           rate, dist_req, mag, left, right, fwd, rem;
      drive_result_type next_drive;
      case (req_kind)
         KIND_SPEED: begin
            target_hdg = wrap_target(int'(req_angle_arg), req_relative_flag);
            spd = int'(req_speed_arg);
            if (spd > 100) spd = 100;
            else if (spd < -100) spd = -100;
            speed_cmd = spd;
         end
         KIND_DISTANCE: begin
            dist_req = longint'(req_distance_arg);
            mag  = (dist_req > 0) ? dist_req : -dist_req;
            target_hdg   = wrap_target(int'(req_angle_arg), req_relative_flag);
            speed_cmd    = (mag > 40) ? 40 : int'(mag);
            dist_target  = dist_req;
            wheel_cnt[0] = '0;
            wheel_cnt[1] = '0;
            settle_hold  = settle_ticks;
         end
         KIND_ENCODER: begin
            if (phase_mem[req_wheel_select] != req_phase_a) begin
               if (req_phase_a == req_phase_b) begin
                  wheel_cnt[req_wheel_select] = wheel_cnt[req_wheel_select] + 1;
               end else begin
                  wheel_cnt[req_wheel_select] = wheel_cnt[req_wheel_select] - 1;
               end
               phase_mem[req_wheel_select] = req_phase_a;
            end
         end
         default: begin
            hdg      = int'(req_heading_deg);
            rate     = longint'(int'(req_gyro_rate_raw) * 2000 / 32768);
            last_hdg = (hdg + 360) % 360;
            err      = (target_hdg - last_hdg + 360) % 360;
            left     = 0;
            right    = 0;
            fwd      = speed_cmd;

            if (err < deadband || err > 360 - deadband) begin
               if (turn_hold != 0) turn_hold--;
            end else if (err < 180) begin
               right = longint'(err) * heading_gain - longint'(rate_gain) * rate + 10;
               if (right < 0) right = 0;
               left = -right;
               turn_hold = settle_ticks;
            end else begin
               left = longint'(360 - err) * heading_gain + longint'(rate_gain) * rate + 10;
               if (left < 0) left = 0;
               right = -left;
               turn_hold = settle_ticks;
            end

            if (dist_target != 0) begin
               rem = dist_target - (longint'(wheel_cnt[0]) + longint'(wheel_cnt[1]));
               if (rem > far_window || rem < -far_window) begin
                  fwd = (rem > 0) ? speed_cmd : -speed_cmd;
                  settle_hold = settle_ticks;
               end else if (rem > near_window || rem < -near_window) begin
                  fwd = (rem > 0) ? creep_speed : -creep_speed;
                  settle_hold = settle_ticks;
               end else begin
                  fwd = 0;
                  if (settle_hold != 0) begin
                     settle_hold--;
                  end else begin
                     dist_target  = 0;
                     wheel_cnt[0] = '0;
                     wheel_cnt[1] = '0;
                     speed_cmd    = 0;
                  end
               end
            end

            next_drive.left      = clamp_drive(fwd + left);
            next_drive.right     = clamp_drive(fwd + right);
            next_drive.turning   = (turn_hold != 0);
            next_drive.traveling = (dist_target != 0);
            next_drive.err       = err[8:0];
            expected_drives.push_back(next_drive);
         end
      endcase
   endtask

   task automatic check_drive();
      drive_result_type want;
      if (expected_drives.size() == 0) begin
         report_mismatch($sformatf("result with none expected: left %0d right %0d err %0d",
                                   rsp_left_drive, rsp_right_drive, rsp_heading_error));
         return;
      end
      want = expected_drives.pop_front();
      if (rsp_left_drive !== want.left)
         report_mismatch($sformatf("left_drive got %0d expected %0d",
                                   rsp_left_drive, want.left));
      if (rsp_right_drive !== want.right)
         report_mismatch($sformatf("right_drive got %0d expected %0d",
                                   rsp_right_drive, want.right));
      if (rsp_turning_busy !== want.turning)
         report_mismatch($sformatf("turning_busy got %b expected %b",
                                   rsp_turning_busy, want.turning));
      if (rsp_distance_busy !== want.traveling)
         report_mismatch($sformatf("distance_busy got %b expected %b",
                                   rsp_distance_busy, want.traveling));
      if (rsp_heading_error !== want.err)
         report_mismatch($sformatf("heading_error got %0d expected %0d",
                                   rsp_heading_error, want.err));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
      end else begin
         if (rsp_valid && rsp_ready) check_drive();
         if (csr_we) write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) advance_controller();
      end
      pending_results = expected_drives.size();
   end

endmodule

// ----- bench/tb_heading_distance_drive_controller.sv -----
// ----------------------------------------------------------------------------
// tb_heading_distance_drive_controller
// Drives ticks, speed and distance commands and encoder edges into the drive
// controller through several register settings and idle patterns; the
// checker beside the block predicts and compares every drive result.
// ----------------------------------------------------------------------------
module tb_heading_distance_drive_controller;

   timeunit 1ns;
   timeprecision 1ps;

   import hddc_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 10;
   localparam int COUNT_BITS   = 24;
   // an item leaves the input register once it advances; leave
   // some margin
   localparam int HOLD_CYCLES  = 4;
   localparam int CYCLE_LIMIT  = 200000;
   // no register lives here; writes to it must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 3'd7;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_kind          = KIND_TICK;
   logic signed [8:0]          req_heading_deg   = '0;
   logic signed [15:0]         req_gyro_rate_raw = '0;
   logic signed [9:0]          req_angle_arg     = '0;
   logic                       req_relative_flag = 1'b0;
   logic signed [15:0]         req_speed_arg     = '0;
   logic signed [23:0]         req_distance_arg  = '0;
   logic                       req_wheel_select  = 1'b0;
   logic                       req_phase_a       = 1'b0;
   logic                       req_phase_b       = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready         = 1'b0;
   logic signed [7:0]          rsp_left_drive;
   logic signed [7:0]          rsp_right_drive;
   logic                       rsp_turning_busy;
   logic                       rsp_distance_busy;
   logic [8:0]                 rsp_heading_error;
   logic                       csr_we            = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index         = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata         = '0;

   int fail_count;
   int pending_results;
   int cycle_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // encoder channel A level last sent per wheel, and the direction that
   // moves the counts toward the current distance target
   logic last_phase_a [2] = '{1'b0, 1'b0};
   logic travel_up        = 1'b1;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   heading_distance_drive_controller #(
      .COUNT_BITS(COUNT_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_heading_deg   (req_heading_deg),
      .req_gyro_rate_raw (req_gyro_rate_raw),
      .req_angle_arg     (req_angle_arg),
      .req_relative_flag (req_relative_flag),
      .req_speed_arg     (req_speed_arg),
      .req_distance_arg  (req_distance_arg),
      .req_wheel_select  (req_wheel_select),
      .req_phase_a       (req_phase_a),
      .req_phase_b       (req_phase_b),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_turning_busy  (rsp_turning_busy),
      .rsp_distance_busy (rsp_distance_busy),
      .rsp_heading_error (rsp_heading_error),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   hddc_drive_checker #(
      .COUNT_BITS(COUNT_BITS)
   ) drive_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_heading_deg   (req_heading_deg),
      .req_gyro_rate_raw (req_gyro_rate_raw),
      .req_angle_arg     (req_angle_arg),
      .req_relative_flag (req_relative_flag),
      .req_speed_arg     (req_speed_arg),
      .req_distance_arg  (req_distance_arg),
      .req_wheel_select  (req_wheel_select),
      .req_phase_a       (req_phase_a),
      .req_phase_b       (req_phase_b),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_turning_busy  (rsp_turning_busy),
      .rsp_distance_busy (rsp_distance_busy),
      .rsp_heading_error (rsp_heading_error),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   // Stall the result channel at random; keep it low while in reset.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog: abort a run that hangs on a handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Present one item at a falling edge, idling first at random, and hold it
   // until the rising edge that completes the transfer.
   task automatic drive_item(input kind_type kind, input logic signed [8:0] hdg,
                             input logic signed [15:0] gyro,
                             input logic signed [9:0] angle, input logic rel,
                             input logic signed [15:0] speed,
                             input logic signed [23:0] dist_counts,
                             input logic wheel, input logic pa, input logic pb);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_kind          <= kind;
      req_heading_deg   <= hdg;
      req_gyro_rate_raw <= gyro;
      req_angle_arg     <= angle;
      req_relative_flag <= rel;
      req_speed_arg     <= speed;
      req_distance_arg  <= dist_counts;
      req_wheel_select  <= wheel;
      req_phase_a       <= pa;
      req_phase_b       <= pb;
      req_valid         <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Fields a kind does not use still get random values, so every bit toggles.
   task automatic send_tick(input logic signed [8:0] hdg, input logic signed [15:0] gyro);
      drive_item(KIND_TICK, hdg, gyro, 10'($urandom), 1'($urandom_range(1)),
                 16'($urandom), 24'($urandom), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic send_speed(input logic signed [9:0] angle, input logic rel,
                             input logic signed [15:0] speed);
      drive_item(KIND_SPEED, 9'($urandom), 16'($urandom), angle, rel, speed,
                 24'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
   endtask

   task automatic send_distance(input logic signed [9:0] angle, input logic rel,
                                input logic signed [23:0] dist_counts);
      travel_up = (dist_counts >= 0);
      drive_item(KIND_DISTANCE, 9'($urandom), 16'($urandom), angle, rel, 16'($urandom),
                 dist_counts, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
   endtask

   task automatic send_edge(input logic wheel, input logic pa, input logic pb);
      // the block stores channel A on every edge, repeated or not
      last_phase_a[wheel] = pa;
      drive_item(KIND_ENCODER, 9'($urandom), 16'($urandom), 10'($urandom),
                 1'($urandom_range(1)), 16'($urandom), 24'($urandom), wheel, pa, pb);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic apply_settings(input int hgain, input int rgain, input int dband,
                                 input int far_win, input int near_win,
                                 input int creep, input int settle);
      write_csr(CSR_HEADING_GAIN, CSR_DATA_BITS'(hgain));
      write_csr(CSR_RATE_GAIN, CSR_DATA_BITS'(rgain));
      write_csr(CSR_DEADBAND, CSR_DATA_BITS'(dband));
      write_csr(CSR_FAR_WINDOW, CSR_DATA_BITS'(far_win));
      write_csr(CSR_NEAR_WINDOW, CSR_DATA_BITS'(near_win));
      write_csr(CSR_CREEP_SPEED, CSR_DATA_BITS'(creep));
      write_csr(CSR_SETTLE_TICKS, CSR_DATA_BITS'(settle));
   endtask

   // Drop valid, drain every expected result, then let the input stage empty:
   // a command or edge item leaves no result behind to wait for.
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (HOLD_CYCLES) @(negedge clock);
   endtask

   // Edge cases with the reset register values: field extremes, every kind,
   // wrap of heading and target, clamps, repeated phase, zero distance and
   // both sides of the deadband.
   task automatic run_directed();
      send_tick(9'sd0, 16'sd0);
      send_speed(10'sd90, 1'b0, 16'sd32767);
      send_tick(-9'sd256, 16'sd32767);
      send_tick(9'sd255, -16'sd32768);
      send_speed(-10'sd512, 1'b1, -16'sd32768);
      send_tick(9'sd180, 16'sd0);
      send_speed(10'sd511, 1'b1, -16'sd101);
      send_tick(-9'sd180, -16'sd1);
      send_distance(10'sd0, 1'b0, 24'sd8388607);
      send_edge(1'b0, 1'b1, 1'b1);
      send_edge(1'b0, 1'b1, 1'b0);   // channel A unchanged: no count
      send_edge(1'b0, 1'b0, 1'b1);
      send_edge(1'b1, 1'b1, 1'b0);
      send_edge(1'b1, 1'b0, 1'b0);
      send_tick(9'sd0, 16'sd0);
      send_distance(-10'sd360, 1'b1, -24'sd8388608);
      send_tick(9'sd90, 16'sd100);
      send_distance(10'sd360, 1'b0, 24'sd0);
      send_tick(9'sd0, 16'sd0);
      send_distance(10'sd0, 1'b0, -24'sd41);
      send_tick(9'sd0, 16'sd0);
      send_speed(10'sd0, 1'b0, 16'sd100);
      send_tick(9'sd5, 16'sd0);
      send_tick(-9'sd5, 16'sd0);
      send_tick(9'sd4, 16'sd0);
      send_tick(-9'sd4, 16'sd0);
   endtask

   // Mostly ticks and encoder edges that walk the counts toward the current
   // distance target, with the occasional new command and noisy edge.
   task automatic send_random(input int count);
      int                 pick;
      logic               wheel, pa, pb;
      logic signed [8:0]  hdg;
      logic signed [15:0] gyro, speed;
      logic signed [9:0]  angle;
      logic signed [23:0] dist_counts;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if ($urandom_range(99) < 80) hdg = 9'(int'($urandom_range(360)) - 180);
         else hdg = 9'($urandom);
         if ($urandom_range(99) < 70) gyro = 16'(int'($urandom_range(6000)) - 3000);
         else gyro = 16'($urandom);
         if ($urandom_range(99) < 60) angle = 10'(int'($urandom_range(720)) - 360);
         else angle = 10'($urandom);
         if (pick < 40) begin
            send_tick(hdg, gyro);
         end else if (pick < 82) begin
            wheel = 1'($urandom_range(1));
            if ($urandom_range(99) < 85) begin
               pa = ~last_phase_a[wheel];
               pb = travel_up ? pa : ~pa;
            end else begin
               pa = 1'($urandom_range(1));
               pb = 1'($urandom_range(1));
            end
            send_edge(wheel, pa, pb);
         end else if (pick < 92) begin
            if ($urandom_range(99) < 85) begin
               dist_counts = 24'(int'($urandom_range(600)) - 300);
            end else begin
               dist_counts = 24'($urandom);
            end
            send_distance(angle, 1'($urandom_range(1)), dist_counts);
         end else begin
            if ($urandom_range(99) < 60) speed = 16'(int'($urandom_range(300)) - 150);
            else speed = 16'($urandom);
            send_speed(angle, 1'($urandom_range(1)), speed);
         end
      end
   endtask

   task automatic random_settings();
      int far_win;
      far_win = $urandom_range(400);
      apply_settings($urandom_range(12), $urandom_range(12), $urandom_range(90),
                     far_win, $urandom_range(far_win), $urandom_range(100),
                     $urandom_range(6));
   endtask

   initial begin
      // Hold reset for the first cycles, release it at a falling edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values, no idling on either side.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_directed();
      send_random(120);
      quiesce();

      // Upper gains, zero deadband and windows, no settling; the spare index
      // must not disturb any register. Sender idles most of the time.
      apply_settings(255, 255, 0, 0, 0, 100, 0);
      write_csr(CSR_SPARE_INDEX, '1);
      sender_idle_pct = 73;
      send_random(140);
      quiesce();

      // Zero gains, widest deadband and windows, longest settle; the
      // receiver stalls most of the time.
      apply_settings(0, 0, 127, 65535, 65535, 127, 255);
      sender_idle_pct    = 0;
      receiver_stall_pct = 73;
      send_random(140);
      quiesce();

      // Near window above the far window: the far test decides first.
      apply_settings(3, 1, 10, 20, 200, 20, 2);
      sender_idle_pct    = 25;
      receiver_stall_pct = 25;
      send_random(140);
      quiesce();

      // Random settings, first without idling, then with both sides idling.
      random_settings();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_random(150);
      quiesce();

      random_settings();
      sender_idle_pct    = 25;
      receiver_stall_pct = 25;
      send_random(150);
      quiesce();

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
